// ===== rtl/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types, constants and the reciprocal table of the 5x5 mean filter.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int RADIUS       = 2;
    localparam int SPAN         = 2 * RADIUS + 1;
    localparam int LINE_ROWS    = 2 * RADIUS;
    localparam int PIX_W        = 8;
    localparam int WCFG_W       = 12;
    localparam int HCFG_W       = 13;
    localparam int ROW_W        = 13;
    localparam int POS_W        = ROW_W + WCFG_W;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int RST_WIDTH    = 2048;
    localparam int RST_HEIGHT   = 1024;
    localparam int COLSUM_W     = 11;
    localparam int SUM_W        = 13;
    localparam int CNT_W        = 5;
    localparam int RECIP_W      = 19;
    localparam int RECIP_SHIFT  = 18;
    localparam int MUL_A_W      = 13;
    localparam int MUL_W        = MUL_A_W + RECIP_W;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // control word shared by every window cell
    typedef struct packed {
        logic            shift;
        logic [SPAN-1:0] row_ok;
    } t_cell_ctl;

    typedef logic [SPAN-1:0][PIX_W-1:0] t_column;

    // ceil(2^18 / n): exact floor division of any 13-bit sum by n
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        m = '0;
        case (n)
            5'd1:    m = 19'd262144;
            5'd2:    m = 19'd131072;
            5'd3:    m = 19'd87382;
            5'd4:    m = 19'd65536;
            5'd5:    m = 19'd52429;
            5'd6:    m = 19'd43691;
            5'd7:    m = 19'd37450;
            5'd8:    m = 19'd32768;
            5'd9:    m = 19'd29128;
            5'd10:   m = 19'd26215;
            5'd11:   m = 19'd23832;
            5'd12:   m = 19'd21846;
            5'd13:   m = 19'd20165;
            5'd14:   m = 19'd18725;
            5'd15:   m = 19'd17477;
            5'd16:   m = 19'd16384;
            5'd17:   m = 19'd15421;
            5'd18:   m = 19'd14564;
            5'd19:   m = 19'd13798;
            5'd20:   m = 19'd13108;
            5'd21:   m = 19'd12484;
            5'd22:   m = 19'd11916;
            5'd23:   m = 19'd11398;
            5'd24:   m = 19'd10923;
            5'd25:   m = 19'd10486;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/mean_filter_5x5_border_clipped_unit.sv =====
// ----------------------------------------------------------------------------
// mean_filter_5x5_border_clipped_unit
// 5x5 box mean over a raster pixel stream, border neighbors clipped.
//
//   channel | direction | tdata              | side band
//   s       | in        | [7:0] pixel        | tuser: drain
//   m       | out       | [7:0] mean_value   | tlast: frame_end
//   cfg     | in        | [12:0] reg value   | idx 0 width, 1 height
//
// A word that yields a result passes the line store read, column shift,
// window sum, reciprocal multiply and output load; a word that does not
// ends after the column shift. The output register lets the next word in
// while a result waits. A register write holds the input while the block
// starts a recompute, forms two products on the shared multiplier and then
// divides the output position bit-serially; only then is the next word
// taken. Reset is synchronous and active low; the line store is not cleared.
// ----------------------------------------------------------------------------
module mean_filter_5x5_border_clipped_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] pixel
    input  logic        i_s_tuser,   // [0] drain
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] mean_value
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [mfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int PW     = mfb_pkg::POS_W;
    localparam int WW     = mfb_pkg::WCFG_W;
    localparam int HW     = mfb_pkg::HCFG_W;
    localparam int CMP_W  = 14;
    localparam int DCNT_W = $clog2(PW + 1);
    localparam int RST_WE = (mfb_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                              : mfb_pkg::RST_WIDTH;
    localparam int RST_NPIX = RST_WE * mfb_pkg::RST_HEIGHT;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_SUM  = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_OUT  = 8'b0001_0000,
        S_RC1  = 8'b0010_0000,
        S_RC2  = 8'b0100_0000,
        S_DIV  = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic [WW-1:0]  r_width;
    logic [HW-1:0]  r_height;
    logic           r_recalc;
    logic [CW-1:0]  r_col;
    logic [mfb_pkg::ROW_W-1:0] r_row;
    logic [PW-1:0]  r_prow, r_npix, r_q, r_i, r_oi;
    logic [WW-1:0]  r_j, r_oj;
    logic [mfb_pkg::PIX_W-1:0] r_samp;
    logic           r_emit, r_last;
    logic [CW-1:0]  r_wcol;
    logic [mfb_pkg::SUM_W-1:0] r_sum;
    logic [mfb_pkg::CNT_W-1:0] r_cnt;
    logic [mfb_pkg::MUL_W-1:0] r_mul;
    logic [PW-1:0]  r_dq;
    logic [WW:0]    r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [7:0]     r_out;
    logic           r_ovalid, r_olast;

    // effective frame size
    logic [WW-1:0] w_e;
    logic [HW-1:0] h_e;
    always_comb begin
        if (r_width == '0) begin
            w_e = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_e = WW'(MAX_WIDTH);
        end else begin
            w_e = r_width;
        end
        if (r_height == '0) begin
            h_e = HW'(1);
        end else if (32'(r_height) > mfb_pkg::HEIGHT_LIMIT) begin
            h_e = HW'(mfb_pkg::HEIGHT_LIMIT);
        end else begin
            h_e = r_height;
        end
    end

    // scan decisions for the word at the port
    logic          accept, emit, last, col_wrap, j_wrap;
    logic [PW-1:0] p, lag;
    logic [mfb_pkg::ROW_W-1:0] row_nx;
    assign accept   = i_s_tvalid && o_s_tready;
    assign p        = r_prow + PW'(r_col);
    assign lag      = PW'({w_e, 1'b0}) + PW'(mfb_pkg::RADIUS);
    assign emit     = p >= lag;
    assign last     = (r_q + PW'(1)) >= r_npix;
    assign col_wrap = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(w_e);
    assign j_wrap   = (CMP_W'(r_j) + CMP_W'(1)) >= CMP_W'(w_e);
    assign row_nx   = r_row + mfb_pkg::ROW_W'(1);

    assign o_s_tready = (r_state == S_IDLE) && !r_recalc;

    // shared multiplier
    logic [mfb_pkg::MUL_A_W-1:0] mul_a;
    logic [mfb_pkg::RECIP_W-1:0] mul_b;
    always_comb begin
        unique case (r_state)
            S_RC1:   begin mul_a = r_row;  mul_b = mfb_pkg::RECIP_W'(w_e); end
            S_RC2:   begin mul_a = h_e;    mul_b = mfb_pkg::RECIP_W'(w_e); end
            default: begin mul_a = r_sum;  mul_b = mfb_pkg::recip(r_cnt);  end
        endcase
    end

    // divider step
    logic [WW:0] rem_sh;
    logic        div_ge;
    assign rem_sh = {r_rem[WW-1:0], r_dq[PW-1]};
    assign div_ge = rem_sh >= {1'b0, w_e};

    // line store
    logic [mfb_pkg::LINE_ROWS-1:0][mfb_pkg::PIX_W-1:0] rd_data, wr_data;
    mfb_pkg::t_column v;
    always_comb begin
        for (int k = 0; k < mfb_pkg::LINE_ROWS; k++) begin
            v[k] = rd_data[k];
        end
        v[mfb_pkg::SPAN-1] = r_samp;
        for (int k = 0; k < mfb_pkg::LINE_ROWS; k++) begin
            wr_data[k] = v[k + 1];
        end
    end

    mfb_lines #(.DEPTH(MAX_WIDTH), .ADDR_W(CW)) u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_LOAD),
        .i_wr_addr (r_wcol),
        .i_wr_data (wr_data)
    );

    // window cells and their masks
    mfb_pkg::t_cell_ctl cell_ctl;
    logic [mfb_pkg::SPAN-1:0] col_ok;
    mfb_pkg::t_column chain [mfb_pkg::SPAN+1];
    logic [mfb_pkg::COLSUM_W-1:0] col_sum [mfb_pkg::SPAN];

    always_comb begin
        cell_ctl.shift = (r_state == S_LOAD);
        for (int r = 0; r < mfb_pkg::SPAN; r++) begin
            cell_ctl.row_ok[r] =
                ((PW+1)'(r_oi) + (PW+1)'(r) >= (PW+1)'(mfb_pkg::RADIUS)) &&
                ((PW+1)'(r_oi) + (PW+1)'(r) < (PW+1)'(h_e) + (PW+1)'(mfb_pkg::RADIUS));
        end
        for (int k = 0; k < mfb_pkg::SPAN; k++) begin
            col_ok[k] =
                (CMP_W'(r_oj) + CMP_W'(k) >= CMP_W'(mfb_pkg::RADIUS)) &&
                (CMP_W'(r_oj) + CMP_W'(k) < CMP_W'(w_e) + CMP_W'(mfb_pkg::RADIUS));
        end
    end

    assign chain[mfb_pkg::SPAN] = v;
    for (genvar g = 0; g < mfb_pkg::SPAN; g++) begin : g_cell
        mfb_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (cell_ctl),
            .i_col_ok (col_ok[g]),
            .i_col    (chain[g + 1]),
            .o_col    (chain[g]),
            .o_sum    (col_sum[g])
        );
    end

    logic [mfb_pkg::SUM_W-1:0] win_sum;
    always_comb begin
        win_sum = '0;
        for (int k = 0; k < mfb_pkg::SPAN; k++) begin
            win_sum = win_sum + mfb_pkg::SUM_W'(col_sum[k]);
        end
    end

    // sequencer, scan counters and recompute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= WW'(mfb_pkg::RST_WIDTH);
            r_height <= HW'(mfb_pkg::RST_HEIGHT);
            r_recalc <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_prow   <= '0;
            r_npix   <= PW'(RST_NPIX);
            r_q      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_emit   <= 1'b0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mfb_pkg::REG_IMAGE_WIDTH) begin
                    r_width <= i_cfg_data[WW-1:0];
                end else begin
                    r_height <= i_cfg_data[HW-1:0];
                end
            end
            // drop the sent word unless the output stage reloads it
            if (r_ovalid && i_m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (r_recalc) begin
                        r_state <= S_RC1;
                    end else if (accept) begin
                        r_state <= S_LOAD;
                        r_samp  <= (p < r_npix && !i_s_tuser) ? i_s_tdata : '0;
                        r_wcol  <= r_col;
                        r_emit  <= emit;
                        r_last  <= emit && last;
                        r_oi    <= r_i;
                        r_oj    <= r_j;
                        if (emit && last) begin
                            // frame done: restart the scan
                            r_col  <= '0;
                            r_row  <= '0;
                            r_prow <= '0;
                            r_q    <= '0;
                            r_i    <= '0;
                            r_j    <= '0;
                        end else begin
                            if (emit) begin
                                r_q <= r_q + PW'(1);
                                if (j_wrap) begin
                                    r_j <= '0;
                                    r_i <= r_i + PW'(1);
                                end else begin
                                    r_j <= r_j + WW'(1);
                                end
                            end
                            if (col_wrap) begin
                                r_col  <= '0;
                                r_row  <= row_nx;
                                r_prow <= (row_nx == '0) ? '0 : r_prow + PW'(w_e);
                            end else begin
                                r_col <= r_col + CW'(1);
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= r_emit ? S_SUM : S_IDLE;
                end
                S_SUM: begin
                    r_sum   <= win_sum;
                    r_cnt   <= mfb_pkg::CNT_W'($countones(cell_ctl.row_ok)) *
                               mfb_pkg::CNT_W'($countones(col_ok));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_mul   <= mul_a * mul_b;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // load when the output register is free
                    if (!r_ovalid || i_m_tready) begin
                        r_out    <= r_mul[mfb_pkg::RECIP_SHIFT +: 8];
                        r_olast  <= r_last;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_RC1: begin
                    r_mul   <= mul_a * mul_b;
                    r_state <= S_RC2;
                end
                S_RC2: begin
                    r_prow  <= PW'(r_mul);
                    r_mul   <= mul_a * mul_b;
                    r_dq    <= r_q;
                    r_rem   <= '0;
                    r_dcnt  <= DCNT_W'(PW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit of position / width per cycle
                    r_npix <= PW'(r_mul);
                    r_dq   <= {r_dq[PW-2:0], div_ge};
                    r_rem  <= div_ge ? rem_sh - {1'b0, w_e} : rem_sh;
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        r_i     <= {r_dq[PW-2:0], div_ge};
                        r_j     <= div_ge ? WW'(rem_sh - {1'b0, w_e}) : WW'(rem_sh);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                r_recalc <= 1'b1;
            end else if (r_state == S_IDLE && r_recalc) begin
                r_recalc <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_olast;

    // column of the output stays inside the row once recomputed
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_recalc) |-> (CMP_W'(r_j) < CMP_W'(w_e)))
        else $error("output column out of range");

    // an accepted word goes to the line store stage next
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOAD))
        else $error("accepted word not loaded");

    // a new result comes only from the output stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output stage");

    // neighbor count never exceeds the window
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= mfb_pkg::CNT_W'(mfb_pkg::SPAN * mfb_pkg::SPAN)))
        else $error("neighbor count too large");

endmodule

// ===== rtl/mfb_cell.sv =====
// ----------------------------------------------------------------------------
// mfb_cell
// One window column: holds SPAN samples, hands them to its left neighbor on
// a shift and gives the masked sum of its column.
// ----------------------------------------------------------------------------
module mfb_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfb_pkg::t_cell_ctl i_ctl,
    input  logic               i_col_ok,
    input  mfb_pkg::t_column   i_col,
    output mfb_pkg::t_column   o_col,
    output logic [mfb_pkg::COLSUM_W-1:0] o_sum
);

    mfb_pkg::t_column r_col;

    // take the column from the right neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctl.shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // sum the in-image rows of this column
    always_comb begin
        o_sum = '0;
        for (int r = 0; r < mfb_pkg::SPAN; r++) begin
            if (i_ctl.row_ok[r] && i_col_ok) begin
                o_sum = o_sum + mfb_pkg::COLSUM_W'(r_col[r]);
            end
        end
    end

endmodule

// ===== rtl/mfb_lines.sv =====
// ----------------------------------------------------------------------------
// mfb_lines
// Line store: one memory bank per stored row, one address per column.
// ----------------------------------------------------------------------------
module mfb_lines #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [mfb_pkg::LINE_ROWS-1:0][mfb_pkg::PIX_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [mfb_pkg::LINE_ROWS-1:0][mfb_pkg::PIX_W-1:0] i_wr_data
);

    for (genvar g = 0; g < mfb_pkg::LINE_ROWS; g++) begin : g_bank
        logic [mfb_pkg::PIX_W-1:0] mem [DEPTH];

        // write one column, read one column with registered data
        always_ff @(posedge i_clk) begin
            if (i_wr_en) begin
                mem[i_wr_addr] <= i_wr_data[g];
            end
            if (i_rd_en) begin
                o_rd_data[g] <= mem[i_rd_addr];
            end
        end
    end

endmodule

// ===== sim/mean_filter_5x5_border_clipped_checker.sv =====
// ----------------------------------------------------------------------------
// mean_filter_5x5_border_clipped_checker
// Watches the pixel, mean and register channels of the 5x5 mean filter,
// tracks the scan, line store and window itself, predicts each mean word and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module mean_filter_5x5_border_clipped_checker #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [7:0]                     i_m_tdata,
    input  logic                           i_m_tlast,
    input  logic                           i_cfg_we,
    input  logic [mfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] mean;
        logic       last;
    } t_mean_word;

    t_mean_word   mean_q[$];
    logic [7:0]   rows_mem[mfb_pkg::LINE_ROWS][MAX_WIDTH];
    logic [7:0]   win[mfb_pkg::SPAN][mfb_pkg::SPAN];
    logic [11:0]  width_reg;
    logic [12:0]  height_reg;
    longint       in_col, in_row, out_pos;

    task automatic report_mismatch(input string what);
        o_errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // advance the scan by one pixel word and queue the mean it yields
    task automatic predict_mean(input logic [7:0] pix, input logic drain);
        longint w, h, npix, lag, p, c, i, j, rr, cc;
        int unsigned sum, cnt;
        logic [7:0] v[mfb_pkg::SPAN];
        logic [7:0] smp;
        t_mean_word mw;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 :
            (height_reg > mfb_pkg::HEIGHT_LIMIT ? mfb_pkg::HEIGHT_LIMIT : height_reg);
        npix = h * w;
        lag = mfb_pkg::RADIUS * w + mfb_pkg::RADIUS;
        p = in_row * w + in_col;
        c = in_col % MAX_WIDTH;
        smp = (p < npix && !drain) ? pix : 8'd0;
        for (int k = 0; k < mfb_pkg::LINE_ROWS; k++) v[k] = rows_mem[k][c];
        v[mfb_pkg::LINE_ROWS] = smp;
        for (int k = 0; k < mfb_pkg::LINE_ROWS; k++) rows_mem[k][c] = v[k+1];
        for (int r = 0; r < mfb_pkg::SPAN; r++) begin
            for (int k = 0; k < mfb_pkg::SPAN - 1; k++) win[r][k] = win[r][k+1];
            win[r][mfb_pkg::SPAN-1] = v[r];
        end
        if (p >= lag) begin
            i = out_pos / w;
            j = out_pos % w;
            sum = 0;
            cnt = 0;
            for (int r = 0; r < mfb_pkg::SPAN; r++) begin
                rr = i + r - mfb_pkg::RADIUS;
                for (int k = 0; k < mfb_pkg::SPAN; k++) begin
                    cc = j + k - mfb_pkg::RADIUS;
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                        sum += win[r][k];
                        cnt++;
                    end
                end
            end
            mw.mean = cnt ? 8'(sum / cnt) : 8'd0;
            mw.last = (out_pos + 1 >= npix);
            mean_q.push_back(mw);
            if (mw.last) begin
                in_col = 0;
                in_row = 0;
                out_pos = 0;
                return;
            end
            out_pos++;
        end
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1) & 13'h1FFF;
        end else begin
            in_col++;
        end
    endtask

    // track registers, pixel words and mean words at each edge
    always @(posedge i_clk) begin
        t_mean_word want;
        if (!i_rst_n) begin
            width_reg  = 12'(mfb_pkg::RST_WIDTH);
            height_reg = 13'(mfb_pkg::RST_HEIGHT);
            in_col = 0;
            in_row = 0;
            out_pos = 0;
            for (int r = 0; r < mfb_pkg::SPAN; r++)
                for (int k = 0; k < mfb_pkg::SPAN; k++) win[r][k] = '0;
            for (int r = 0; r < mfb_pkg::LINE_ROWS; r++)
                for (int k = 0; k < MAX_WIDTH; k++) rows_mem[r][k] = '0;
            mean_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (mean_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected mean word %0d", i_m_tdata));
                end else begin
                    want = mean_q.pop_front();
                    if (i_m_tdata !== want.mean)
                        report_mismatch($sformatf("mean %0d, want %0d",
                                                  i_m_tdata, want.mean));
                    if (i_m_tlast !== want.last)
                        report_mismatch($sformatf("frame end %0b, want %0b",
                                                  i_m_tlast, want.last));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == mfb_pkg::REG_IMAGE_WIDTH) width_reg = i_cfg_data[11:0];
                else if (i_cfg_idx == mfb_pkg::REG_IMAGE_HEIGHT)
                    height_reg = i_cfg_data[12:0];
            end
            if (i_s_tvalid && i_s_tready) predict_mean(i_s_tdata, i_s_tuser);
        end
        o_pending = mean_q.size();
    end

endmodule

// ===== sim/mean_filter_5x5_border_clipped_unit_tb.sv =====
// ----------------------------------------------------------------------------
// mean_filter_5x5_border_clipped_unit_tb
// Streams frames of several sizes, with drain tails, into the 5x5 mean filter
// under random idling on both sides and one long output stall; the checker
// predicts every mean word and counts mismatches.
// ----------------------------------------------------------------------------
module mean_filter_5x5_border_clipped_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [7:0]                     i_s_tdata;
    logic                           i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [7:0]                     o_m_tdata;
    logic                           o_m_tlast;
    logic                           i_cfg_we;
    logic [mfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [mfb_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int                             errors;
    int                             pending;
    int                             src_idle_pct;
    int                             snk_idle_pct;
    logic                           hold_off;
    int                             quiet_cycles;

    mean_filter_5x5_border_clipped_unit DUT (.*);

    mean_filter_5x5_border_clipped_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls unless a long hold-off is running
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog: count cycles in which no word moves on any channel
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // offer one pixel word and wait until it is taken
    task automatic send_word(input logic [7:0] pix, input logic drain);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        i_s_tuser  <= drain;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mfb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mfb_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        // let the recompute finish before the next word
        repeat (40) @(negedge i_clk);
    endtask

    // one whole frame: constant or random pixels by mode, some drains in random mode, then the drain tail
    task automatic run_frame(input int w, input int h, input int mode);
        logic [7:0] pix;
        for (int n = 0; n < w * h; n++) begin
            case (mode)
                0: pix = 8'hFF;
                1: pix = 8'h00;
                default: pix = 8'($urandom_range(255));
            endcase
            send_word(pix, mode > 1 && $urandom_range(19) == 0);
        end
        for (int n = 0; n < 2 * w + 2; n++)
            send_word(8'($urandom_range(255)), $urandom_range(3) != 0);
        wait_idle();
    endtask

    initial begin
        int w, h;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = mfb_pkg::REG_IMAGE_WIDTH;
        i_cfg_data = '0;
        hold_off   = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extreme pixels, width and height zero, width one, tiny frames
        write_reg(mfb_pkg::REG_IMAGE_WIDTH, 13'd5);
        write_reg(mfb_pkg::REG_IMAGE_HEIGHT, 13'd3);
        run_frame(5, 3, 0);
        run_frame(5, 3, 1);
        write_reg(mfb_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_reg(mfb_pkg::REG_IMAGE_HEIGHT, 13'd0);
        run_frame(1, 1, 2);
        write_reg(mfb_pkg::REG_IMAGE_WIDTH, 13'd1);
        write_reg(mfb_pkg::REG_IMAGE_HEIGHT, 13'd4);
        run_frame(1, 4, 2);

        // random frames under three idling profiles
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 69 : 0;
            snk_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 24 : 0;
            for (int f = 0; f < 6; f++) begin
                w = $urandom_range(1, 16);
                h = $urandom_range(1, 10);
                write_reg(mfb_pkg::REG_IMAGE_WIDTH, 13'(w));
                write_reg(mfb_pkg::REG_IMAGE_HEIGHT, 13'(h));
                if (phase == 2 && f == 0) begin
                    // long output stall while pixels keep coming
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (300) @(negedge i_clk);
                            hold_off = 1'b0;
                        end
                        run_frame(w, h, 2);
                    join
                end else begin
                    run_frame(w, h, 2);
                end
            end
        end

        // register extremes: over-wide width, then over-tall height set
        // mid-frame so the new values apply to a scan in progress
        write_reg(mfb_pkg::REG_IMAGE_WIDTH, 13'hFFF);
        write_reg(mfb_pkg::REG_IMAGE_HEIGHT, 13'd1);
        for (int n = 0; n < 250; n++) send_word(8'($urandom_range(255)), 1'b0);
        wait_idle();
        write_reg(mfb_pkg::REG_IMAGE_WIDTH, 13'd1);
        write_reg(mfb_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
        for (int n = 0; n < 250; n++)
            send_word(8'($urandom_range(255)), $urandom_range(19) == 0);

        wait_idle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mfb_pkg.sv
rtl/mfb_cell.sv
rtl/mfb_lines.sv
rtl/mean_filter_5x5_border_clipped_unit.sv
sim/mean_filter_5x5_border_clipped_checker.sv
sim/mean_filter_5x5_border_clipped_unit_tb.sv
